/* sv/lnac_pkg.sv */
`default_nettype none

package lnac_pkg;

   localparam int CAPACITY   = 16;
   localparam int KEY_BITS   = 64;
   localparam int IP_BITS    = 32;
   localparam int SLOTS      = CAPACITY + 1;
   localparam int ADDR_BITS  = $clog2(SLOTS);
   // counts and ranks reach SLOTS itself
   localparam int COUNT_BITS = $clog2(SLOTS + 1);
   localparam int ENTRY_BITS = KEY_BITS + IP_BITS;

   localparam logic CMD_LOOKUP = 1'b0;
   localparam logic CMD_INSERT = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_UPDATE = 3'b100
   } state_type;

endpackage

`default_nettype wire

/* sv/lru_name_address_cache.sv */
`default_nettype none

// Channel   Dir  Ports                               Content
// req_      in   tvalid/tready/tdata[95:0]/tuser     key + address, tuser = command
// rsp_      out  tvalid/tready/tdata[31:0]/tuser     found address, tuser = hit flag
//
// Each transaction walks all SLOTS entries through one shared key comparator, one
// slot a cycle out of the entry RAM (registered read), then does the recency
// update in the ST_UPDATE state, lookup or insert alike; the slot scan through the
// single RAM read port takes up most of each transaction.
// Synchronous reset clears the valid bits, ranks and fill count at once; no sweep.
// A lookup result sits in the output register; the next request is accepted while it
// waits, and the block holds in the update step only if a new result finds it full.

module lru_name_address_cache (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [95:0] req_tdata,   // [63:0] domain_key, [95:64] ip_addr
   input  wire logic        req_tuser,   // [0] cmd
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] found_ip
   output logic             rsp_tuser    // [0] hit
);

   localparam int AB = lnac_pkg::ADDR_BITS;
   localparam int CB = lnac_pkg::COUNT_BITS;
   localparam int KB = lnac_pkg::KEY_BITS;
   localparam int IB = lnac_pkg::IP_BITS;
   localparam int NS = lnac_pkg::SLOTS;

   lnac_pkg::state_type state_ff, state_in;

   logic          cmd_ff, cmd_in;
   logic [KB-1:0] key_ff, key_in;
   logic [IB-1:0] ip_ff, ip_in;

   logic [CB-1:0] scan_ff, scan_in;
   logic          chk_vld_ff, chk_vld_in;
   logic [AB-1:0] chk_slot_ff, chk_slot_in;

   logic          found_ff, found_in;
   logic [AB-1:0] best_slot_ff, best_slot_in;
   logic [CB-1:0] best_rank_ff, best_rank_in;
   logic [IB-1:0] best_ip_ff, best_ip_in;

   logic          valid_ff [NS];
   logic          valid_in [NS];
   logic [CB-1:0] rank_ff [NS];
   logic [CB-1:0] rank_in [NS];
   logic [CB-1:0] fill_ff, fill_in;

   logic          rsp_vld_ff, rsp_vld_in;
   logic          rsp_hit_ff, rsp_hit_in;
   logic [IB-1:0] rsp_ip_ff, rsp_ip_in;

   logic                             wr_en;
   logic [AB-1:0]                    wr_addr;
   logic [lnac_pkg::ENTRY_BITS-1:0]  wr_data;
   logic [AB-1:0]                    rd_addr;
   logic [lnac_pkg::ENTRY_BITS-1:0]  rd_data;

   logic          req_fire;
   logic          full;
   logic          rsp_free;
   logic          slot_valid;
   logic [CB-1:0] slot_rank;
   logic          do_promote;
   logic [AB-1:0] pro_slot;
   logic [CB-1:0] pro_rank;

   // Key and address of every slot live in one RAM, read one slot a cycle
   lnac_ram #(
      .WIDTH (lnac_pkg::ENTRY_BITS),
      .DEPTH (lnac_pkg::SLOTS)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == lnac_pkg::ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign full       = (fill_ff == CB'(NS));
   assign rsp_free   = !rsp_vld_ff || rsp_tready;
   assign rd_addr    = scan_ff[AB-1:0];
   assign slot_valid = valid_ff[chk_slot_ff];
   assign slot_rank  = rank_ff[chk_slot_ff];

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = rsp_ip_ff;

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      key_in       = key_ff;
      ip_in        = ip_ff;
      scan_in      = scan_ff;
      chk_vld_in   = 1'b0;
      chk_slot_in  = scan_ff[AB-1:0];
      found_in     = found_ff;
      best_slot_in = best_slot_ff;
      best_rank_in = best_rank_ff;
      best_ip_in   = best_ip_ff;
      fill_in      = fill_ff;
      rsp_vld_in   = rsp_vld_ff && !rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_ip_in    = rsp_ip_ff;
      wr_en        = 1'b0;
      wr_addr      = fill_ff[AB-1:0];
      wr_data      = {ip_ff, key_ff};
      do_promote   = 1'b0;
      pro_slot     = best_slot_ff;
      pro_rank     = best_rank_ff;
      for (int i = 0; i < NS; i++) begin
         valid_in[i] = valid_ff[i];
      end

      case (state_ff)
         lnac_pkg::ST_IDLE: begin
            if (req_fire) begin
               cmd_in   = req_tuser;
               key_in   = req_tdata[KB-1:0];
               ip_in    = req_tdata[64 +: IB];
               scan_in  = '0;
               found_in = 1'b0;
               state_in = lnac_pkg::ST_SCAN;
            end
         end

         lnac_pkg::ST_SCAN: begin
            // issue one read per cycle; compare the slot read last cycle
            if (scan_ff < CB'(NS)) begin
               chk_vld_in = 1'b1;
               scan_in    = scan_ff + CB'(1);
            end
            if (chk_vld_ff) begin
               if (cmd_ff == lnac_pkg::CMD_LOOKUP) begin
                  if (slot_valid && rd_data[KB-1:0] == key_ff &&
                      (!found_ff || slot_rank < best_rank_ff)) begin
                     found_in     = 1'b1;
                     best_slot_in = chk_slot_ff;
                     best_rank_in = slot_rank;
                     best_ip_in   = rd_data[KB +: IB];
                  end
               end else begin
                  // victim: the least recent slot
                  if (slot_valid && slot_rank == CB'(NS - 1)) begin
                     best_slot_in = chk_slot_ff;
                  end
               end
               if (chk_slot_ff == AB'(NS - 1)) begin
                  state_in = lnac_pkg::ST_UPDATE;
               end
            end
         end

         lnac_pkg::ST_UPDATE: begin
            if (cmd_ff == lnac_pkg::CMD_LOOKUP) begin
               if (rsp_free) begin
                  rsp_vld_in = 1'b1;
                  rsp_hit_in = found_ff;
                  rsp_ip_in  = found_ff ? best_ip_ff : '0;
                  do_promote = found_ff;
                  state_in   = lnac_pkg::ST_IDLE;
               end
            end else begin
               wr_en      = 1'b1;
               do_promote = 1'b1;
               if (full) begin
                  wr_addr  = best_slot_ff;
                  pro_slot = best_slot_ff;
                  pro_rank = CB'(NS - 1);
               end else begin
                  wr_addr  = fill_ff[AB-1:0];
                  pro_slot = fill_ff[AB-1:0];
                  pro_rank = CB'(NS);
                  fill_in  = fill_ff + CB'(1);
               end
               valid_in[wr_addr] = 1'b1;
               state_in = lnac_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = lnac_pkg::ST_IDLE;
         end
      endcase

      // move the chosen slot to the front; everything ahead of it drops back one
      for (int i = 0; i < NS; i++) begin
         rank_in[i] = rank_ff[i];
         if (do_promote) begin
            if (pro_slot == AB'(i)) begin
               rank_in[i] = '0;
            end else if (valid_ff[i] && rank_ff[i] < pro_rank) begin
               rank_in[i] = rank_ff[i] + CB'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= lnac_pkg::ST_IDLE;
         scan_ff    <= '0;
         chk_vld_ff <= 1'b0;
         found_ff   <= 1'b0;
         fill_ff    <= '0;
         rsp_vld_ff <= 1'b0;
         for (int i = 0; i < NS; i++) begin
            valid_ff[i] <= 1'b0;
            rank_ff[i]  <= '0;
         end
      end else begin
         state_ff   <= state_in;
         scan_ff    <= scan_in;
         chk_vld_ff <= chk_vld_in;
         found_ff   <= found_in;
         fill_ff    <= fill_in;
         rsp_vld_ff <= rsp_vld_in;
         for (int i = 0; i < NS; i++) begin
            valid_ff[i] <= valid_in[i];
            rank_ff[i]  <= rank_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      key_ff       <= key_in;
      ip_ff        <= ip_in;
      chk_slot_ff  <= chk_slot_in;
      best_slot_ff <= best_slot_in;
      best_rank_ff <= best_rank_in;
      best_ip_ff   <= best_ip_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_ip_ff    <= rsp_ip_in;
   end

endmodule

`default_nettype wire

/* sv/lnac_ram.sv */
`default_nettype none

module lnac_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

`default_nettype wire
